// ===== sv/nearest_upsample_gather_address_defines.svh =====
// Assertion macros shared by the upsample gather address RTL.
`ifndef NEAREST_UPSAMPLE_GATHER_ADDRESS_DEFINES_SVH
`define NEAREST_UPSAMPLE_GATHER_ADDRESS_DEFINES_SVH

// Same-cycle implication.
`define NUGA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NUGA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication that is checked during reset too.
`define NUGA_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/nugu_pkg.sv =====
// Shared widths and register indexes for the upsample gather address block.
package nugu_pkg;
   localparam int IDX_W  = 31;
   localparam int DIM_W  = 16;
   localparam int SCL_W  = 8;
   localparam int ADDR_W = 32;
   localparam int CSR_W  = 31;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT = 3'd0,
      CSR_OUT_HEIGHT    = 3'd1,
      CSR_OUT_WIDTH     = 3'd2,
      CSR_SCALE         = 3'd3,
      CSR_SRC_BASE      = 3'd4,
      CSR_DST_BASE      = 3'd5,
      CSR_ELEMENT_COUNT = 3'd6
   } csr_index_type;
endpackage

// ===== sv/nugu_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module nugu_div #(
   parameter int W  = 16,
   parameter int DW = 8,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [W-1:0]  num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side,
   output logic          out_vld,
   output logic [W-1:0]  quo,
   output logic [DW-1:0] rem,
   output logic [SW-1:0] side_out
);
   localparam int AW = DW + W;

   logic [AW-1:0] acc_ff  [0:W];
   logic [DW-1:0] den_ff  [0:W-1];
   logic [SW-1:0] side_ff [0:W];
   logic          vld_ff  [0:W];

   function automatic logic [AW-1:0] div_step(logic [AW-1:0] acc, logic [DW-1:0] d);
      logic [AW:0] sh;
      logic [DW:0] top;
      logic [DW:0] diff;
      sh   = {acc, 1'b0};
      top  = sh[AW:W];
      diff = top - {1'b0, d};
      if (top >= {1'b0, d}) return {diff[DW-1:0], sh[W-1:1], 1'b1};
      return {top[DW-1:0], sh[W-1:1], 1'b0};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= W; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int k = 0; k < W; k++) vld_ff[k+1] <= vld_ff[k];
      end
      if (en) begin
         acc_ff[0]  <= {{DW{1'b0}}, num};
         den_ff[0]  <= den;
         side_ff[0] <= side;
         for (int k = 0; k < W; k++) begin
            acc_ff[k+1]  <= div_step(acc_ff[k], den_ff[k]);
            side_ff[k+1] <= side_ff[k];
         end
         for (int k = 0; k < W - 1; k++) den_ff[k+1] <= den_ff[k];
      end
   end

   assign out_vld  = vld_ff[W];
   assign quo      = acc_ff[W][W-1:0];
   assign rem      = acc_ff[W][AW-1:W];
   assign side_out = side_ff[W];
endmodule

// ===== sv/nugu_addr.sv =====
// Source index recomposition and base offset stages.
module nugu_addr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_vld,
   input  logic [nugu_pkg::IDX_W-1:0]  idx,
   input  logic [nugu_pkg::IDX_W-1:0]  plane,
   input  logic [nugu_pkg::DIM_W-1:0]  row_s,
   input  logic [nugu_pkg::DIM_W-1:0]  col_s,
   input  logic [nugu_pkg::DIM_W-1:0]  ih,
   input  logic [nugu_pkg::DIM_W-1:0]  iw,
   input  logic [nugu_pkg::CSR_W-1:0]  src_base,
   input  logic [nugu_pkg::CSR_W-1:0]  dst_base,
   output logic                        out_vld,
   output logic [nugu_pkg::ADDR_W-1:0] src_addr,
   output logic [nugu_pkg::ADDR_W-1:0] dst_addr
);
   import nugu_pkg::*;

   logic                 vld1_ff, vld2_ff, vld3_ff;
   logic [IDX_W-1:0]     t1_ff, t2_ff, idx1_ff, idx2_ff;
   logic [DIM_W-1:0]     row1_ff, col1_ff, col2_ff, iw1_ff;
   logic [ADDR_W-1:0]    src_ff, dst_ff;
   logic [IDX_W+DIM_W-1:0] t1_in, t2_in;
   logic [IDX_W-1:0]     sum_in;

   always_comb begin
      t1_in  = plane * ih;
      sum_in = t1_ff + {{(IDX_W-DIM_W){1'b0}}, row1_ff};
      t2_in  = sum_in * iw1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      if (en) begin
         t1_ff   <= t1_in[IDX_W-1:0];
         idx1_ff <= idx;
         row1_ff <= row_s;
         col1_ff <= col_s;
         iw1_ff  <= iw;
         t2_ff   <= t2_in[IDX_W-1:0];
         idx2_ff <= idx1_ff;
         col2_ff <= col1_ff;
         src_ff  <= {1'b0, src_base} + {1'b0, t2_ff}
                    + {{(ADDR_W-DIM_W){1'b0}}, col2_ff};
         dst_ff  <= {1'b0, dst_base} + {1'b0, idx2_ff};
      end
   end

   assign out_vld  = vld3_ff;
   assign src_addr = src_ff;
   assign dst_addr = dst_ff;
endmodule

// ===== sv/nearest_upsample_gather_address.sv =====
// Requests pass through three divider pipelines (idx/width, quotient/height, then row,
// column and plane sizes by scale) and three recomposition stages to rsp_tvalid.
// Throughput: one request per cycle; the whole pipeline stalls only while a result
// waits on rsp_tready. Out-of-range indices are dropped at entry.
// Reset (synchronous) clears all valid bits and restores register defaults.
`include "nearest_upsample_gather_address_defines.svh"
module nearest_upsample_gather_address (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // [30:0] out_index
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,  // [31:0] src_addr, [63:32] dst_addr
   input  logic                           csr_we,
   input  logic [nugu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [nugu_pkg::CSR_W-1:0]     csr_wdata
);
   import nugu_pkg::*;

   logic [DIM_W-1:0] out_height_ff, out_width_ff;
   logic [SCL_W-1:0] scale_ff;
   logic [CSR_W-1:0] src_base_ff, dst_base_ff, element_count_ff;
   logic [DIM_W-1:0] nh, nw;
   logic [SCL_W-1:0] sc;
   logic             adv, in_vld;
   logic [IDX_W-1:0] idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_height_ff    <= DIM_W'(1);
         out_width_ff     <= DIM_W'(1);
         scale_ff         <= SCL_W'(1);
         src_base_ff      <= '0;
         dst_base_ff      <= '0;
         element_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: ;  // plane index already spans batch and channel
            CSR_OUT_HEIGHT:    out_height_ff    <= csr_wdata[DIM_W-1:0];
            CSR_OUT_WIDTH:     out_width_ff     <= csr_wdata[DIM_W-1:0];
            CSR_SCALE:         scale_ff         <= csr_wdata[SCL_W-1:0];
            CSR_SRC_BASE:      src_base_ff      <= csr_wdata;
            CSR_DST_BASE:      dst_base_ff      <= csr_wdata;
            CSR_ELEMENT_COUNT: element_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nh = (out_height_ff == '0) ? DIM_W'(1) : out_height_ff;
   assign nw = (out_width_ff == '0) ? DIM_W'(1) : out_width_ff;
   assign sc = (scale_ff == '0) ? SCL_W'(1) : scale_ff;

   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign idx        = req_tdata[IDX_W-1:0];
   assign in_vld     = req_tvalid && (idx < element_count_ff);

   logic             v1;
   logic [IDX_W-1:0] q1, idx1;
   logic [DIM_W-1:0] col1;

   nugu_div #(.W(IDX_W), .DW(DIM_W), .SW(IDX_W)) u_div_w (
      .clock, .reset, .en(adv), .in_vld(in_vld), .num(idx), .den(nw), .side(idx),
      .out_vld(v1), .quo(q1), .rem(col1), .side_out(idx1)
   );

   logic                   v2;
   logic [IDX_W-1:0]       plane2;
   logic [DIM_W-1:0]       row2;
   logic [IDX_W+DIM_W-1:0] side2;

   nugu_div #(.W(IDX_W), .DW(DIM_W), .SW(IDX_W+DIM_W)) u_div_h (
      .clock, .reset, .en(adv), .in_vld(v1), .num(q1), .den(nh), .side({idx1, col1}),
      .out_vld(v2), .quo(plane2), .rem(row2), .side_out(side2)
   );

   logic [3:0]           v3;
   logic [DIM_W-1:0]     col_s, row_s, ih, iw;
   logic [2*IDX_W-1:0]   side3;

   nugu_div #(.W(DIM_W), .DW(SCL_W), .SW(2*IDX_W)) u_div_col (
      .clock, .reset, .en(adv), .in_vld(v2), .num(side2[DIM_W-1:0]), .den(sc),
      .side({side2[IDX_W+DIM_W-1:DIM_W], plane2}),
      .out_vld(v3[0]), .quo(col_s), .rem(), .side_out(side3)
   );
   nugu_div #(.W(DIM_W), .DW(SCL_W), .SW(1)) u_div_row (
      .clock, .reset, .en(adv), .in_vld(v2), .num(row2), .den(sc), .side(1'b0),
      .out_vld(v3[1]), .quo(row_s), .rem(), .side_out()
   );
   nugu_div #(.W(DIM_W), .DW(SCL_W), .SW(1)) u_div_ih (
      .clock, .reset, .en(adv), .in_vld(v2), .num(nh), .den(sc), .side(1'b0),
      .out_vld(v3[2]), .quo(ih), .rem(), .side_out()
   );
   nugu_div #(.W(DIM_W), .DW(SCL_W), .SW(1)) u_div_iw (
      .clock, .reset, .en(adv), .in_vld(v2), .num(nw), .den(sc), .side(1'b0),
      .out_vld(v3[3]), .quo(iw), .rem(), .side_out()
   );

   logic [ADDR_W-1:0] src_addr, dst_addr;

   nugu_addr u_addr (
      .clock, .reset, .en(adv), .in_vld(v3[0]),
      .idx(side3[2*IDX_W-1:IDX_W]), .plane(side3[IDX_W-1:0]),
      .row_s(row_s), .col_s(col_s), .ih(ih), .iw(iw),
      .src_base(src_base_ff), .dst_base(dst_base_ff),
      .out_vld(rsp_tvalid), .src_addr(src_addr), .dst_addr(dst_addr)
   );

   assign rsp_tdata = {dst_addr, src_addr};

   logic [ADDR_W-1:0] dst_off;
   assign dst_off = dst_addr - {1'b0, dst_base_ff};

   `NUGA_ASSERT_NOW(a_lanes_agree, 1'b1, (v3 == 4'b0000) || (v3 == 4'b1111),
      "scale divider lanes lost step")
   `NUGA_ASSERT_NOW(a_dst_in_range, rsp_tvalid, dst_off < {1'b0, element_count_ff},
      "response for out-of-range request")
   `NUGA_ASSERT_ALWAYS(a_reset_empty, !reset && $past(reset), !rsp_tvalid,
      "response valid right after reset")
   `NUGA_ASSERT_NEXT(a_drop_range, req_tvalid && req_tready && !in_vld, !u_div_w.vld_ff[0],
      "out-of-range request entered pipeline")
endmodule
